// ===== src/text_console_writer_top_defines.svh =====
// Assertion macros used by the console writer's top level.
`ifndef TEXT_CONSOLE_WRITER_TOP_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define TCW_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define TCW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/tcw_pkg.sv =====
// Types and constants shared by the text console writer modules.
package tcw_pkg;

    // Fixed field widths of the command, result and configuration beats.
    localparam int ACTION_W    = 2;
    localparam int CHAR_W      = 8;
    localparam int ADDRESS_W   = 11;
    localparam int CELL_W      = 16;
    localparam int CURSOR_W    = 11;
    localparam int ATTR_W      = 8;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;

    // Action codes.
    localparam logic [ACTION_W-1:0] ACT_PUT   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_READ  = 2'd2;

    // Control characters.
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;

    // Configuration register indexes and reset values.
    localparam logic [CFG_IDX_W-1:0] REG_TEXT_ATTR   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_CURSOR_CELL = 1'b1;
    localparam logic [ATTR_W-1:0]    ATTR_RESET        = 8'h0f;
    localparam logic [CELL_W-1:0]    CURSOR_CELL_RESET = 16'h0fb1;

    typedef struct packed {
        logic [ACTION_W-1:0]  action;
        logic [CHAR_W-1:0]    char_code;
        logic [ADDRESS_W-1:0] cell_address;
    } t_in_item;

    typedef struct packed {
        logic [CELL_W-1:0]   cell_data;
        logic [CURSOR_W-1:0] cursor_position;
        logic                scrolled;
    } t_out_item;

    // Decoded operation of one command beat.
    typedef enum logic [2:0] {
        OP_CHAR,
        OP_NEWLINE,
        OP_TAB,
        OP_BACK,
        OP_CLEAR,
        OP_READ,
        OP_NOP
    } t_op;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_PUT,
        S_TAB,
        S_MARK,
        S_COPY,
        S_CLR_ROW,
        S_CLEAR,
        S_READ,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        CUR_HOLD,
        CUR_INC,
        CUR_NEWLINE,
        CUR_BACK,
        CUR_HOME,
        CUR_LAST_ROW
    } t_cur_op;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_ZERO_CUR,
        WR_CHAR_CUR,
        WR_MARK_CUR,
        WR_ZERO_SWEEP,
        WR_COPY
    } t_wr_sel;

    typedef enum logic [1:0] {
        RD_NONE,
        RD_ADDR,
        RD_COPY
    } t_rd_sel;

    // Controller to datapath.
    typedef struct packed {
        logic    load;
        t_cur_op cur_op;
        t_wr_sel wr_sel;
        t_rd_sel rd_sel;
        logic    sweep_clr;
        logic    sweep_inc;
        logic    set_scrolled;
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        t_op  in_op;
        t_op  op;
        logic wrap;
        logic tab_end;
        logic sweep_zero;
        logic sweep_copy_end;
        logic sweep_last;
    } t_stat;

endpackage

// ===== src/tcw_ctrl.sv =====
// Sequencing state machine of the text console writer.
module tcw_ctrl
    import tcw_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_stat i_stat,
    output logic  o_busy,
    output logic  o_done,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_INIT: begin
                if (i_stat.sweep_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_start) begin
                    unique case (i_stat.in_op)
                        OP_CHAR, OP_NEWLINE, OP_BACK: n_state = S_PUT;
                        OP_TAB:                       n_state = S_TAB;
                        OP_CLEAR:                     n_state = S_CLEAR;
                        OP_READ:                      n_state = S_READ;
                        default:                      n_state = S_DONE;
                    endcase
                end
            end
            S_PUT: begin
                n_state = S_MARK;
            end
            S_TAB: begin
                if (i_stat.tab_end) n_state = S_MARK;
            end
            S_MARK: begin
                n_state = i_stat.wrap ? S_COPY : S_DONE;
            end
            S_COPY: begin
                if (i_stat.sweep_copy_end) n_state = S_CLR_ROW;
            end
            S_CLR_ROW, S_CLEAR: begin
                if (i_stat.sweep_last) n_state = S_MARK;
            end
            S_READ: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        o_cmd        = '{load: 1'b0, cur_op: CUR_HOLD, wr_sel: WR_NONE, rd_sel: RD_NONE,
                         sweep_clr: 1'b0, sweep_inc: 1'b0, set_scrolled: 1'b0};
        o_busy       = (r_state != S_IDLE);
        o_done       = (r_state == S_DONE);
        unique case (r_state)
            S_INIT: begin
                o_cmd.wr_sel    = WR_ZERO_SWEEP;
                o_cmd.sweep_inc = 1'b1;
            end
            S_IDLE: begin
                o_cmd.load      = i_start;
                o_cmd.sweep_clr = i_start;
            end
            S_PUT: begin
                unique case (i_stat.op)
                    OP_CHAR: begin
                        o_cmd.wr_sel = WR_CHAR_CUR;
                        o_cmd.cur_op = CUR_INC;
                    end
                    OP_NEWLINE: begin
                        o_cmd.wr_sel = WR_ZERO_CUR;
                        o_cmd.cur_op = CUR_NEWLINE;
                    end
                    OP_BACK: begin
                        o_cmd.wr_sel = WR_ZERO_CUR;
                        o_cmd.cur_op = CUR_BACK;
                    end
                    default: ;
                endcase
            end
            S_TAB: begin
                o_cmd.wr_sel = WR_ZERO_CUR;
                o_cmd.cur_op = CUR_INC;
            end
            S_MARK: begin
                if (i_stat.wrap) begin
                    o_cmd.set_scrolled = 1'b1;
                    o_cmd.sweep_clr    = 1'b1;
                end else begin
                    o_cmd.wr_sel = WR_MARK_CUR;
                end
            end
            S_COPY: begin
                if (!i_stat.sweep_copy_end) begin
                    o_cmd.rd_sel    = RD_COPY;
                    o_cmd.sweep_inc = 1'b1;
                end
                if (!i_stat.sweep_zero) o_cmd.wr_sel = WR_COPY;
            end
            S_CLR_ROW: begin
                o_cmd.wr_sel    = WR_ZERO_SWEEP;
                o_cmd.sweep_inc = 1'b1;
                if (i_stat.sweep_last) o_cmd.cur_op = CUR_LAST_ROW;
            end
            S_CLEAR: begin
                o_cmd.wr_sel    = WR_ZERO_SWEEP;
                o_cmd.sweep_inc = 1'b1;
                if (i_stat.sweep_last) o_cmd.cur_op = CUR_HOME;
            end
            S_READ: begin
                o_cmd.rd_sel = RD_ADDR;
            end
            S_DONE: ;
            default: ;
        endcase
    end

endmodule

// ===== src/tcw_dp.sv =====
// Datapath of the text console writer: cell store, cursor and registers.
module tcw_dp
    import tcw_pkg::*;
#(
    parameter int COLUMNS   = 80,
    parameter int ROWS      = 25,
    parameter int TAB_WIDTH = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_in_item              i_item,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_cmd                  i_cmd,
    output t_stat                 o_stat,
    output t_out_item             o_result
);

    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int LAST_ROW   = CELL_COUNT - COLUMNS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int CUR_W      = $clog2(CELL_COUNT + 1);
    localparam int COL_W      = $clog2(COLUMNS);
    localparam int PH_W       = (TAB_WIDTH > 1) ? $clog2(TAB_WIDTH) : 1;
    localparam int BACK_PHASE = (COLUMNS - 1) % TAB_WIDTH;

    logic [CELL_W-1:0] r_mem [CELL_COUNT];
    logic [CELL_W-1:0] r_rdata;

    t_in_item          r_item;
    t_op               r_op;
    t_op               n_in_op;
    logic              r_scrolled;
    logic [ATTR_W-1:0] r_attr;
    logic [CELL_W-1:0] r_cursor_cell;

    logic [CUR_W-1:0]  r_cur;
    logic [CUR_W-1:0]  n_cur;
    logic [COL_W-1:0]  r_col;
    logic [COL_W-1:0]  n_col;
    logic [PH_W-1:0]   r_phase;
    logic [PH_W-1:0]   n_phase;
    logic [PH_W-1:0]   phase_up;
    logic [PH_W-1:0]   phase_down;
    logic [ADDR_W-1:0] r_sweep;

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [CELL_W-1:0] wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              addr_ok;

    // Decode of the command beat on the input.
    always_comb begin
        unique case (i_item.action)
            ACT_PUT: begin
                case (i_item.char_code) inside
                    CH_NEWLINE, CH_RETURN: n_in_op = OP_NEWLINE;
                    CH_TAB:                n_in_op = OP_TAB;
                    CH_BACKSPACE:          n_in_op = OP_BACK;
                    default:               n_in_op = OP_CHAR;
                endcase
            end
            ACT_CLEAR: n_in_op = OP_CLEAR;
            ACT_READ:  n_in_op = OP_READ;
            default:   n_in_op = OP_NOP;
        endcase
    end

    // Latched command beat; payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_item <= i_item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op       <= OP_NOP;
            r_scrolled <= 1'b0;
        end else if (i_cmd.load) begin
            r_op       <= n_in_op;
            r_scrolled <= 1'b0;
        end else if (i_cmd.set_scrolled) begin
            r_scrolled <= 1'b1;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr        <= ATTR_RESET;
            r_cursor_cell <= CURSOR_CELL_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_TEXT_ATTR:   r_attr        <= i_cfg_data[ATTR_W-1:0];
                REG_CURSOR_CELL: r_cursor_cell <= i_cfg_data[CELL_W-1:0];
                default: ;
            endcase
        end
    end

    // Cursor, its column and its place between tab stops.
    assign phase_up   = (r_phase == PH_W'(TAB_WIDTH - 1)) ? '0 : PH_W'(r_phase + 1'b1);
    assign phase_down = (r_phase == '0) ? PH_W'(TAB_WIDTH - 1) : PH_W'(r_phase - 1'b1);

    always_comb begin
        n_cur   = r_cur;
        n_col   = r_col;
        n_phase = r_phase;
        unique case (i_cmd.cur_op)
            CUR_INC: begin
                n_cur = CUR_W'(r_cur + 1'b1);
                if (r_col == COL_W'(COLUMNS - 1)) begin
                    n_col   = '0;
                    n_phase = '0;
                end else begin
                    n_col   = COL_W'(r_col + 1'b1);
                    n_phase = phase_up;
                end
            end
            CUR_NEWLINE: begin
                n_cur   = CUR_W'(r_cur + CUR_W'(COLUMNS) - CUR_W'(r_col));
                n_col   = '0;
                n_phase = '0;
            end
            CUR_BACK: begin
                if (r_cur != '0) begin
                    n_cur = CUR_W'(r_cur - 1'b1);
                    if (r_col == '0) begin
                        n_col   = COL_W'(COLUMNS - 1);
                        n_phase = PH_W'(BACK_PHASE);
                    end else begin
                        n_col   = COL_W'(r_col - 1'b1);
                        n_phase = phase_down;
                    end
                end
            end
            CUR_HOME: begin
                n_cur   = '0;
                n_col   = '0;
                n_phase = '0;
            end
            CUR_LAST_ROW: begin
                n_cur   = CUR_W'(LAST_ROW);
                n_col   = '0;
                n_phase = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur   <= '0;
            r_col   <= '0;
            r_phase <= '0;
        end else begin
            r_cur   <= n_cur;
            r_col   <= n_col;
            r_phase <= n_phase;
        end
    end

    // Sweep counter for clearing and scrolling passes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep <= '0;
        end else if (i_cmd.sweep_clr) begin
            r_sweep <= '0;
        end else if (i_cmd.sweep_inc) begin
            r_sweep <= ADDR_W'(r_sweep + 1'b1);
        end
    end

    // Write port selection.
    always_comb begin
        wr_en   = 1'b1;
        wr_addr = ADDR_W'(r_cur);
        wr_data = '0;
        unique case (i_cmd.wr_sel)
            WR_ZERO_CUR: wr_data = '0;
            WR_CHAR_CUR: wr_data = {r_attr, r_item.char_code};
            WR_MARK_CUR: wr_data = r_cursor_cell;
            WR_ZERO_SWEEP: begin
                wr_addr = r_sweep;
                wr_data = '0;
            end
            WR_COPY: begin
                wr_addr = ADDR_W'(r_sweep - 1'b1);
                wr_data = r_rdata;
            end
            default: wr_en = 1'b0;
        endcase
    end

    // Read port selection; the scroll reads one row ahead of the write.
    always_comb begin
        rd_en   = 1'b1;
        rd_addr = ADDR_W'(r_item.cell_address);
        unique case (i_cmd.rd_sel)
            RD_ADDR: rd_addr = ADDR_W'(r_item.cell_address);
            RD_COPY: rd_addr = ADDR_W'(r_sweep + ADDR_W'(COLUMNS));
            default: rd_en = 1'b0;
        endcase
    end

    // Cell store with registered read data.
    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[wr_addr] <= wr_data;
        if (rd_en) r_rdata <= r_mem[rd_addr];
    end

    // Status to the controller.
    always_comb begin
        o_stat.in_op          = n_in_op;
        o_stat.op             = r_op;
        o_stat.wrap           = (r_cur == CUR_W'(CELL_COUNT));
        o_stat.tab_end        = (r_col == COL_W'(COLUMNS - 1)) ||
                                (r_phase == PH_W'(TAB_WIDTH - 1));
        o_stat.sweep_zero     = (r_sweep == '0);
        o_stat.sweep_copy_end = (r_sweep == ADDR_W'(LAST_ROW));
        o_stat.sweep_last     = (r_sweep == ADDR_W'(CELL_COUNT - 1));
    end

    // Result beat; addresses beyond the screen read as zero.
    assign addr_ok = (32'(r_item.cell_address) < CELL_COUNT);

    always_comb begin
        o_result.cell_data       = (r_op == OP_READ && addr_ok) ? r_rdata : '0;
        o_result.cursor_position = CURSOR_W'(r_cur);
        o_result.scrolled        = r_scrolled;
    end

endmodule

// ===== src/text_console_writer_top.sv =====
// Top level of the text console writer: controller, datapath and checks.
//
//  Channel   Direction  Handshake                Beat
//  command   in         start high, busy low     i_item   (action, char, address)
//  result    out        o_done, one cycle        o_result (cell, cursor, scrolled)
//  config    in         i_cfg_we, no wait        i_cfg_idx, i_cfg_data
//
// A printable character, newline or backspace passes through the put, mark and
// done states; a tab writes its blanks in the tab state, then marks. A scroll
// adds one copy pass with the single write port of the cell store, then a pass
// clearing the last row. A clear zeroes every cell and homes the cursor before
// marking it; a read passes through the read state, and an unused action goes
// straight to done. After reset the store is cleared one cell a cycle, with
// busy high. The result strobe cannot be held off by the receiver.
`include "text_console_writer_top_defines.svh"

module text_console_writer_top
    import tcw_pkg::*;
#(
    parameter int COLUMNS   = 80,
    parameter int ROWS      = 25,
    parameter int TAB_WIDTH = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  t_in_item              i_item,
    output logic                  o_done,
    output t_out_item             o_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int LAST_ROW = COLUMNS * (ROWS - 1);

    t_cmd  cmd;
    t_stat stat;
    logic  accept;

    assign accept = start && !busy;

    tcw_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_busy  (busy),
        .o_done  (o_done),
        .o_cmd   (cmd)
    );

    tcw_dp #(
        .COLUMNS   (COLUMNS),
        .ROWS      (ROWS),
        .TAB_WIDTH (TAB_WIDTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_result   (o_result)
    );

    // An accepted beat keeps the block busy for at least the next cycle.
    `TCW_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, accept, busy, "accepted beat did not occupy the block")
    // The result strobe is the last busy cycle.
    `TCW_ASSERT_NEXT(a_done_idle, i_clk, i_rst_n, o_done, !busy, "block still busy after result strobe")
    // A result never reports the cursor beyond the screen.
    `TCW_ASSERT_NOW(a_cursor_on_screen, i_clk, i_rst_n, o_done, !stat.wrap, "cursor past screen end at result")
    // A scroll always leaves the cursor at the start of the last row.
    `TCW_ASSERT_NOW(a_scroll_cursor, i_clk, i_rst_n, o_done && o_result.scrolled, o_result.cursor_position == CURSOR_W'(LAST_ROW), "scroll left cursor off the last row")

endmodule

// ===== verif/tb_text_console_writer_top.sv =====
// Self-checking testbench for the text console writer: command beats in, one result beat out.
`timescale 1ns / 1ps

module tb_text_console_writer_top;
    import tcw_pkg::*;

    localparam int COLS      = 80;
    localparam int ROW_COUNT = 25;
    localparam int TAB_STEP  = 4;
    localparam int CELLS     = COLS * ROW_COUNT;

    // Action code that the block must ignore.
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    localparam int ITEM_TARGET    = 1250;
    localparam int IDLE_PERCENT   = 36;
    localparam int DRAIN_LIMIT    = 10000;
    localparam int SETTLE_CYCLES  = 8;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    t_in_item              i_item;
    logic                  o_done;
    t_out_item             o_result;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // Shadow copy of the screen, cursor and registers.
    logic [CELL_W-1:0] screen_shadow [0:CELLS-1];
    int unsigned       cursor_shadow;
    logic [ATTR_W-1:0] attr_shadow;
    logic [CELL_W-1:0] marker_shadow;

    t_out_item   pending_results[$];
    int unsigned error_count;
    int unsigned items_sent;
    bit          idle_on;

    text_console_writer_top #(
        .COLUMNS  (COLS),
        .ROWS     (ROW_COUNT),
        .TAB_WIDTH(TAB_STEP)
    ) uut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_item    (i_item),
        .o_done    (o_done),
        .o_result  (o_result),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // Hard stop in case the block hangs.
    initial begin
        #250_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic report_mismatch(string what, int unsigned want, int unsigned got);
        $display("%0t ERROR %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
        error_count++;
    endtask

    // Clears the shadow screen as the block does after reset or a clear.
    function automatic void blank_screen();
        for (int i = 0; i < CELLS; i++) begin
            screen_shadow[i] = '0;
        end
    endfunction

    function automatic void store_cell(int unsigned pos, logic [CELL_W-1:0] value);
        if (pos < CELLS) begin
            screen_shadow[pos] = value;
        end
    endfunction

    // Applies one command to the shadow state and returns the result it should produce.
    function automatic t_out_item console_predict(t_in_item cmd);
        t_out_item   res;
        int unsigned col;
        int unsigned blanks;
        res = '0;
        case (cmd.action)
            ACT_PUT: begin
                col = cursor_shadow % COLS;
                if (cmd.char_code == CH_NEWLINE || cmd.char_code == CH_RETURN) begin
                    store_cell(cursor_shadow, '0);
                    cursor_shadow += COLS - col;
                end else if (cmd.char_code == CH_TAB) begin
                    // Blanks up to the next tab stop, never past the end of the row.
                    blanks = TAB_STEP - (col % TAB_STEP);
                    if (blanks > COLS - col) begin
                        blanks = COLS - col;
                    end
                    for (int i = 0; i < blanks; i++) begin
                        store_cell(cursor_shadow, '0);
                        cursor_shadow++;
                    end
                end else if (cmd.char_code == CH_BACKSPACE) begin
                    store_cell(cursor_shadow, '0);
                    if (cursor_shadow != 0) begin
                        cursor_shadow--;
                    end
                end else begin
                    store_cell(cursor_shadow, {attr_shadow, cmd.char_code});
                    cursor_shadow++;
                end
                // Past the end: move every row up and blank the last one.
                if (cursor_shadow >= CELLS) begin
                    for (int i = 0; i < CELLS - COLS; i++) begin
                        screen_shadow[i] = screen_shadow[i + COLS];
                    end
                    for (int i = CELLS - COLS; i < CELLS; i++) begin
                        screen_shadow[i] = '0;
                    end
                    cursor_shadow = CELLS - COLS;
                    res.scrolled  = 1'b1;
                end
                store_cell(cursor_shadow, marker_shadow);
            end
            ACT_CLEAR: begin
                blank_screen();
                cursor_shadow = 0;
                store_cell(cursor_shadow, marker_shadow);
            end
            ACT_READ: begin
                if (cmd.cell_address < CELLS) begin
                    res.cell_data = screen_shadow[cmd.cell_address];
                end
            end
            default: begin
            end
        endcase
        res.cursor_position = cursor_shadow[CURSOR_W-1:0];
        return res;
    endfunction

    function automatic t_in_item make_cmd(logic [ACTION_W-1:0] act, logic [CHAR_W-1:0] ch,
                                          logic [ADDRESS_W-1:0] addr);
        t_in_item cmd;
        cmd.action       = act;
        cmd.char_code    = ch;
        cmd.cell_address = addr;
        return cmd;
    endfunction

    // Mostly printable text with tabs, backspaces and any other byte mixed in.
    function automatic logic [CHAR_W-1:0] random_text_byte();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            return CH_TAB;
        end else if (pick < 14) begin
            return CH_BACKSPACE;
        end else if (pick < 34) begin
            return CHAR_W'($urandom_range(0, 255));
        end
        return CHAR_W'($urandom_range(32, 126));
    endfunction

    // Sends one command beat, with random idle cycles first while idle_on is set, and records its result.
    task automatic send_command(t_in_item cmd);
        while (idle_on && $urandom_range(0, 99) < IDLE_PERCENT) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
        @(negedge i_clk);
        start  <= 1'b1;
        i_item <= cmd;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
        pending_results.push_back(console_predict(cmd));
        items_sent++;
    endtask

    task automatic send_put(logic [CHAR_W-1:0] ch);
        send_command(make_cmd(ACT_PUT, ch, ADDRESS_W'($urandom_range(0, 2047))));
    endtask

    task automatic send_read(logic [ADDRESS_W-1:0] addr);
        send_command(make_cmd(ACT_READ, CHAR_W'($urandom_range(0, 255)), addr));
    endtask

    // Stops sending and waits until every expected result has come and the block is idle.
    task automatic wait_results_drained();
        int unsigned waited;
        waited = 0;
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
    endtask

    // Register write; only called while the block is idle.
    task automatic write_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == REG_TEXT_ATTR) begin
            attr_shadow = data[ATTR_W-1:0];
        end else begin
            marker_shadow = data;
        end
    endtask

    // One line of text, usually short, usually ended by a newline or a return.
    task automatic send_text_line();
        int unsigned len;
        int unsigned ending;
        len = ($urandom_range(0, 99) < 15) ? $urandom_range(40, 95) : $urandom_range(0, 12);
        for (int i = 0; i < len; i++) begin
            send_put(random_text_byte());
        end
        ending = $urandom_range(0, 99);
        if (ending < 45) begin
            send_put(CH_NEWLINE);
        end else if (ending < 90) begin
            send_put(CH_RETURN);
        end
    endtask

    // Reads either anywhere in the address space or close to the cursor.
    task automatic send_probe_read();
        int signed addr;
        if ($urandom_range(0, 1) == 0) begin
            addr = int'($urandom_range(0, 2047));
        end else begin
            addr = int'(cursor_shadow) + int'($urandom_range(0, 6)) - 4;
        end
        send_read(addr[ADDRESS_W-1:0]);
    endtask

    // Each result beat is checked against the oldest expectation.
    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result beat with nothing pending", 0, 32'(o_result));
            end else begin
                want = pending_results.pop_front();
                if (o_result.cell_data !== want.cell_data) begin
                    report_mismatch("cell_data", 32'(want.cell_data), 32'(o_result.cell_data));
                end
                if (o_result.cursor_position !== want.cursor_position) begin
                    report_mismatch("cursor_position", 32'(want.cursor_position),
                                    32'(o_result.cursor_position));
                end
                if (o_result.scrolled !== want.scrolled) begin
                    report_mismatch("scrolled", 32'(want.scrolled), 32'(o_result.scrolled));
                end
            end
        end
    end

    // Blank screen with no marker, the ignored action and a backspace at home.
    task automatic test_reset_state();
        send_read(11'd0);
        send_read(11'd1999);
        send_command(make_cmd(ACT_UNUSED, 8'hff, 11'h7ff));
        send_put(CH_BACKSPACE);
        send_read(11'd0);
    endtask

    // Character extremes, both line endings, tab stops and backspace.
    task automatic test_put_controls();
        send_command(make_cmd(ACT_CLEAR, 8'h00, 11'h000));
        send_put(8'h41);
        send_put(CH_TAB);
        send_put(CH_TAB);
        send_put(CH_BACKSPACE);
        send_put(CH_NEWLINE);
        send_put(8'h00);
        send_put(8'hff);
        send_put(CH_RETURN);
        send_read(11'd0);
        send_read(11'd1);
        send_read(11'd7);
        send_read(11'd80);
        send_read(11'd81);
        send_read(11'd82);
        send_read(11'd160);
        send_read(11'd2000);
        send_read(11'd2047);
        send_command(make_cmd(ACT_UNUSED, 8'h00, 11'h000));
    endtask

    // Extreme and reset register settings, each followed by some text.
    task automatic test_config_extremes();
        logic [CFG_DATA_W-1:0] attr_set [3];
        logic [CFG_DATA_W-1:0] mark_set [3];
        attr_set = '{16'h0000, 16'h00ff, 16'(ATTR_RESET)};
        mark_set = '{16'h0000, 16'hffff, CURSOR_CELL_RESET};
        for (int s = 0; s < 3; s++) begin
            wait_results_drained();
            write_config(REG_TEXT_ATTR, attr_set[s]);
            write_config(REG_CURSOR_CELL, mark_set[s]);
            send_text_line();
            send_put(8'h5a);
            send_probe_read();
            send_read(cursor_shadow[ADDRESS_W-1:0]);
        end
    endtask

    // Mostly well-formed text with reads, clears and some noise, in phases.
    task automatic test_random_console();
        int unsigned phase;
        int unsigned phase_end;
        int unsigned pick;
        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            // Registers change only between phases, once the block has gone quiet.
            wait_results_drained();
            if (phase % 3 == 1) begin
                write_config(REG_TEXT_ATTR, CFG_DATA_W'($urandom_range(0, 65535)));
                write_config(REG_CURSOR_CELL, CFG_DATA_W'($urandom_range(0, 65535)));
            end else if (phase % 3 == 2) begin
                write_config(REG_TEXT_ATTR, 16'h00ff);
                write_config(REG_CURSOR_CELL, 16'h0000);
            end
            idle_on   = (phase != 3);
            phase_end = items_sent + 115;
            while (items_sent < phase_end && items_sent < ITEM_TARGET) begin
                pick = $urandom_range(0, 99);
                if (pick < 66) begin
                    send_text_line();
                end else if (pick < 86) begin
                    send_probe_read();
                end else if (pick < 90) begin
                    send_command(make_cmd(ACT_UNUSED, CHAR_W'($urandom_range(0, 255)),
                                          ADDRESS_W'($urandom_range(0, 2047))));
                end else if (pick < 93) begin
                    send_command(make_cmd(ACT_CLEAR, CHAR_W'($urandom_range(0, 255)),
                                          ADDRESS_W'($urandom_range(0, 2047))));
                end else begin
                    // Broken text: bursts of backspaces or tabs.
                    repeat ($urandom_range(1, 10)) begin
                        send_put(($urandom_range(0, 1) == 0) ? CH_BACKSPACE : CH_TAB);
                    end
                end
            end
            phase++;
        end
        idle_on = 1'b1;
    endtask

    initial begin
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_item        = '0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = '0;
        i_cfg_data    = '0;
        error_count   = 0;
        items_sent    = 0;
        idle_on       = 1'b1;
        blank_screen();
        cursor_shadow = 0;
        attr_shadow   = ATTR_RESET;
        marker_shadow = CURSOR_CELL_RESET;

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_put_controls();
        test_config_extremes();
        test_random_console();
        wait_results_drained();

        if (pending_results.size() != 0) begin
            report_mismatch("results never returned", pending_results.size(), 0);
        end
        if (error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+src
src/tcw_pkg.sv
src/tcw_ctrl.sv
src/tcw_dp.sv
src/text_console_writer_top.sv
verif/tb_text_console_writer_top.sv
